// ===== hdl/fifo_queue_with_delete_by_value_unit_defines.svh =====
// Assertion macros for the queue with delete by value.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef FIFO_QUEUE_WITH_DELETE_BY_VALUE_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_VALUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/fqd_pkg.sv =====
// Package for the queue with delete by value: types, codes and sizes.
// No dependencies.
package fqd_pkg;

  localparam int WORD_W      = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef logic signed [WORD_W-1:0] word_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  remove;
    word_t value;
  } cmd_t;

endpackage

// ===== hdl/fqd_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
// Depends on fqd_pkg.
interface fqd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [fqd_pkg::MODE_W-1:0]           mode;
  logic signed [fqd_pkg::WORD_W-1:0]    item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink (input valid, input mode, input item_value, output ready);
endinterface

interface fqd_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fqd_pkg::WORD_W-1:0]    popped_value;
  logic [fqd_pkg::STATUS_W-1:0]         status;
  logic [fqd_pkg::COUNT_OUT_W-1:0]      entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input popped_value, input status, input entry_count,
                output ready);
endinterface

// ===== hdl/fqd_cell.sv =====
// One storage cell of the queue chain: holds a word, compares it, shifts.
// Depends on fqd_pkg.
module fqd_cell (
  input  logic          clk,
  input  fqd_pkg::cmd_t cmd,
  input  logic          live,
  input  logic          tail,
  input  fqd_pkg::word_t right_data,
  input  logic          found_in,
  output fqd_pkg::word_t data,
  output logic          found_out
);

  logic match;
  logic shift;
  logic load;

  assign match     = cmd.remove && live && (data == cmd.value);
  assign found_out = found_in || match;
  assign shift     = cmd.pop || (cmd.remove && found_out);
  assign load      = cmd.push && tail;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= right_data;
    end else if (load) begin
      data <= cmd.value;
    end
  end

endmodule

// ===== hdl/fifo_queue_with_delete_by_value_unit.sv =====
// Top level of the queue with delete by value: chain of cells plus count.
// Depends on fqd_pkg, fqd_if, fqd_cell and the assertion macro header.
//
// Usage:
//   req channel carries mode and item_value; rsp channel returns
//   popped_value, status and entry_count, one rsp item per req item.
//   Push appends at the tail, pop takes the head, remove deletes the
//   oldest equal entry and closes the gap. Mode 3 does nothing, status ok.
//   The rsp item is valid in the cycle after the req item is taken.
//   Throughput: one item per cycle while rsp is ready. All cells compare and shift in the
//   cycle of acceptance; the first-match flag ripples along the cell chain.
//   Reset clears the entry count and the response valid flag; the cells keep
//   stale words, which are never shown because only live cells are read.
//   When rsp stalls the result is held and req.ready stays low until it
//   is taken; with rsp ready, req.ready stays high.
`include "fifo_queue_with_delete_by_value_unit_defines.svh"

module fifo_queue_with_delete_by_value_unit #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  fqd_req_if.sink   req,
  fqd_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  fqd_pkg::cmd_t         cmd;
  fqd_pkg::word_t        cell_data [DEPTH];
  logic [DEPTH:0]        found;
  logic                  accept;
  logic                  full;
  logic                  empty;
  fqd_pkg::status_t      status_next;
  fqd_pkg::word_t        popped_next;
  logic [CW+fqd_pkg::COUNT_OUT_W-1:0] count_wide;

  logic                  res_valid;
  fqd_pkg::word_t        res_popped;
  fqd_pkg::status_t      res_status;
  logic [fqd_pkg::COUNT_OUT_W-1:0] res_count;

  assign req.ready = !res_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    cmd.push   = 1'b0;
    cmd.pop    = 1'b0;
    cmd.remove = 1'b0;
    cmd.value  = req.item_value;
    if (accept) begin
      case (fqd_pkg::mode_t'(req.mode))
        fqd_pkg::MODE_PUSH:   cmd.push   = !full;
        fqd_pkg::MODE_POP:    cmd.pop    = !empty;
        fqd_pkg::MODE_REMOVE: cmd.remove = 1'b1;
        default: ;
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqd_pkg::word_t right;
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    fqd_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .live       (CW'(i) < count),
      .tail       (CW'(i) == count),
      .right_data (right),
      .found_in   (found[i]),
      .data       (cell_data[i]),
      .found_out  (found[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = fqd_pkg::ST_OK;
    popped_next = '0;
    case (fqd_pkg::mode_t'(req.mode))
      fqd_pkg::MODE_PUSH: begin
        if (full) begin
          status_next = fqd_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      fqd_pkg::MODE_POP: begin
        if (empty) begin
          status_next = fqd_pkg::ST_EMPTY;
        end else begin
          count_next  = count - 1'b1;
          popped_next = cell_data[0];
        end
      end
      fqd_pkg::MODE_REMOVE: begin
        if (found[DEPTH]) begin
          count_next = count - 1'b1;
        end else begin
          status_next = fqd_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  assign count_wide = {{fqd_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_popped <= popped_next;
      res_status <= status_next;
      res_count  <= count_wide[fqd_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.popped_value = res_popped;
  assign rsp.status       = res_status;
  assign rsp.entry_count  = res_count;

  `FQD_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `FQD_ASSERT_NEXT(a_accept_gives_result, accept, res_valid)
  `FQD_ASSERT_NEXT(a_full_push_holds, accept && (req.mode == fqd_pkg::MODE_PUSH) && full,
                   (count == CW'(DEPTH)) && (res_status == fqd_pkg::ST_FULL))
  `FQD_ASSERT_NOW(a_error_no_value, res_valid && (res_status != fqd_pkg::ST_OK),
                  res_popped == '0)

endmodule

// ===== bench/tb_fifo_queue_with_delete_by_value_unit.sv =====
// Self-checking bench for fifo_queue_with_delete_by_value_unit: directed, back-pressure
// and random push/pop/remove traffic, checked against a queue model kept in the bench.
// Depends on fqd_pkg, fqd_if and the RTL top level.
module tb_fifo_queue_with_delete_by_value_unit;

  localparam int DEPTH = fqd_pkg::DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [fqd_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
  localparam fqd_pkg::word_t WMIN = 32'sh8000_0000;
  localparam fqd_pkg::word_t WMAX = 32'sh7FFF_FFFF;

  typedef struct {
    fqd_pkg::word_t                  popped;
    logic [fqd_pkg::STATUS_W-1:0]    status;
    logic [fqd_pkg::COUNT_OUT_W-1:0] count;
  } reply_t;

  logic clk;
  logic rst;

  fqd_req_if req_ch ();
  fqd_rsp_if rsp_ch ();

  fifo_queue_with_delete_by_value_unit #(.DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fqd_pkg::word_t queue_words[$];
  reply_t         replies_due[$];
  fqd_pkg::word_t value_pool[6] = '{WMIN, WMAX, 32'sd0, -32'sd1, 32'sd1, 32'sd42};
  bit             quiet = 1'b0;
  int             hold_cycles = 0;
  int             mismatches = 0;
  int             items_sent = 0;
  int             replies_seen = 0;
  int             full_seen = 0;
  int             empty_seen = 0;
  int             miss_seen = 0;
  int unsigned    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_fifo_queue_with_delete_by_value_unit: errors");
      $finish;
    end
  end

  function automatic reply_t predict_reply(logic [fqd_pkg::MODE_W-1:0] op,
                                           fqd_pkg::word_t val);
    reply_t r;
    int     hit;
    r.popped = '0;
    r.status = fqd_pkg::ST_OK;
    hit = -1;
    case (op)
      fqd_pkg::MODE_PUSH: begin
        if (queue_words.size() >= DEPTH) r.status = fqd_pkg::ST_FULL;
        else queue_words.push_back(val);
      end
      fqd_pkg::MODE_POP: begin
        if (queue_words.size() == 0) r.status = fqd_pkg::ST_EMPTY;
        else r.popped = queue_words.pop_front();
      end
      fqd_pkg::MODE_REMOVE: begin
        foreach (queue_words[i]) if (hit < 0 && queue_words[i] == val) hit = i;
        if (hit < 0) r.status = fqd_pkg::ST_NOT_FOUND;
        else queue_words.delete(hit);
      end
      default: ;
    endcase
    r.count = fqd_pkg::COUNT_OUT_W'(queue_words.size());
    return r;
  endfunction

  // accepted requests feed the model
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      replies_due.push_back(predict_reply(req_ch.mode, req_ch.item_value));
  end

  // accepted results are compared with the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      case (rsp_ch.status)
        fqd_pkg::ST_FULL:      full_seen++;
        fqd_pkg::ST_EMPTY:     empty_seen++;
        fqd_pkg::ST_NOT_FOUND: miss_seen++;
        default: ;
      endcase
      if (replies_due.size() == 0) begin
        $error("result with nothing pending: popped_value %0d status %0d entry_count %0d",
               rsp_ch.popped_value, rsp_ch.status, rsp_ch.entry_count);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.popped_value !== want.popped) begin
          $error("popped_value: expected %0d, got %0d", want.popped, rsp_ch.popped_value);
          mismatches++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
          mismatches++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: runs of ready with random stalls, plus requested hold-offs
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (quiet) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic [fqd_pkg::MODE_W-1:0] op, input fqd_pkg::word_t val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= op;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  function automatic fqd_pkg::word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && queue_words.size() > 0)
      return queue_words[$urandom_range(0, queue_words.size() - 1)];
    if (r < 7) return value_pool[$urandom_range(0, 5)];
    return fqd_pkg::word_t'($urandom);
  endfunction

  function automatic logic [fqd_pkg::MODE_W-1:0] pick_mode(int push_w, int pop_w, int rem_w);
    int r;
    if ($urandom_range(0, 99) < 3) return MODE_NOP;
    r = $urandom_range(1, push_w + pop_w + rem_w);
    if (r <= push_w) return fqd_pkg::MODE_PUSH;
    if (r <= push_w + pop_w) return fqd_pkg::MODE_POP;
    return fqd_pkg::MODE_REMOVE;
  endfunction

  task automatic test_directed();
    send_item(fqd_pkg::MODE_POP, 32'sd0);
    send_item(fqd_pkg::MODE_REMOVE, WMAX);
    send_item(MODE_NOP, -32'sd1);
    send_item(fqd_pkg::MODE_PUSH, WMIN);
    send_item(fqd_pkg::MODE_PUSH, WMAX);
    send_item(fqd_pkg::MODE_PUSH, 32'sd0);
    send_item(fqd_pkg::MODE_PUSH, -32'sd1);
    send_item(fqd_pkg::MODE_PUSH, 32'sd7);
    send_item(fqd_pkg::MODE_PUSH, 32'sd7);
    send_item(fqd_pkg::MODE_PUSH, 32'sd3);
    send_item(fqd_pkg::MODE_PUSH, 32'sd7);
    repeat (DEPTH - 8) send_item(fqd_pkg::MODE_PUSH, fqd_pkg::word_t'($urandom));
    send_item(fqd_pkg::MODE_PUSH, WMAX);
    send_item(MODE_NOP, 32'sd0);
    send_item(fqd_pkg::MODE_REMOVE, 32'sd7);
    send_item(fqd_pkg::MODE_REMOVE, 32'sh1234_5678);
    send_item(fqd_pkg::MODE_REMOVE, WMIN);
    send_item(fqd_pkg::MODE_REMOVE, WMAX);
    send_item(fqd_pkg::MODE_POP, 32'sd0);
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_cycles = 80;
    repeat (24) send_item(pick_mode(5, 3, 2), pick_value());
    quiet = 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    int sent;
    int burst;
    int pw;
    int ow;
    int rw;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(10, 60);
      if (burst > n_items - sent) burst = n_items - sent;
      quiet = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
        0:       begin pw = 7; ow = 2; rw = 2; end
        1:       begin pw = 2; ow = 6; rw = 2; end
        2:       begin pw = 4; ow = 1; rw = 5; end
        default: begin pw = 4; ow = 3; rw = 3; end
      endcase
      repeat (burst) begin
        send_item(pick_mode(pw, ow, rw), pick_value());
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_streaming(input int n_items);
    quiet = 1'b1;
    repeat (n_items) send_item(pick_mode(4, 3, 3), pick_value());
    quiet = 1'b0;
  endtask

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= fqd_pkg::MODE_PUSH;
    req_ch.item_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random_mix(1060);
    test_streaming(50);
    test_backpressure();

    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d items sent, %0d results checked", items_sent, replies_seen);
    $display("rejected: %0d full, %0d empty, %0d not found", full_seen, empty_seen, miss_seen);
    if (mismatches == 0) begin
      $display("tb_fifo_queue_with_delete_by_value_unit: clean");
    end else begin
      $display("tb_fifo_queue_with_delete_by_value_unit: errors");
    end
    $finish;
  end

endmodule

// ===== fifo_queue_with_delete_by_value_unit.f =====
+incdir+hdl
hdl/fqd_pkg.sv
hdl/fqd_if.sv
hdl/fqd_cell.sv
hdl/fifo_queue_with_delete_by_value_unit.sv
bench/tb_fifo_queue_with_delete_by_value_unit.sv
